// ===== design/sll_pkg.sv =====
package sll_pkg;

   // Field widths of the sample path and the control registers.
   localparam int SAMPLE_W  = 24;
   localparam int LEVEL_W   = 23;
   localparam int GAIN_W    = 25;
   localparam int COEF_W    = 16;
   localparam int DLEN_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 25;

   // Fraction bits of the gain words (Q7.18).
   localparam int FRAC_BITS = 18;

   // Serial multiplier: operand width and step counter width.
   localparam int MUL_W     = 25;
   localparam int MUL_CNT_W = $clog2(MUL_W + 1);

   // Product of the output lanes after the Q7.18 scaling shift.
   localparam int SCALED_W  = 2 * MUL_W - FRAC_BITS;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SAMPLE_W-1:0]        mag_type;
   typedef logic [LEVEL_W-1:0]         level_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic [COEF_W-1:0]          coef_type;
   typedef logic [DLEN_W-1:0]          dlen_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic [CSR_W-1:0]           csr_data_type;
   typedef logic [FRAC_BITS-1:0]       quo_type;
   typedef logic [MUL_W-1:0]           mul_word_type;
   typedef logic [MUL_CNT_W-1:0]       mul_cnt_type;
   typedef logic [SCALED_W-1:0]        scaled_type;

   // Command to a serial multiplier lane.
   typedef struct packed {
      logic        start;
      mul_cnt_type steps;
   } mul_cmd_type;

   // Step counts for the different products.
   localparam mul_cnt_type STEPS_COEF = mul_cnt_type'(COEF_W);
   localparam mul_cnt_type STEPS_FRAC = mul_cnt_type'(FRAC_BITS);
   localparam mul_cnt_type STEPS_FULL = mul_cnt_type'(MUL_W);

   // Register indexes of the control port.
   localparam csr_idx_type CSR_THRESHOLD    = 3'd0;
   localparam csr_idx_type CSR_MAKEUP_GAIN  = 3'd1;
   localparam csr_idx_type CSR_CEILING      = 3'd2;
   localparam csr_idx_type CSR_RELEASE_COEF = 3'd3;
   localparam csr_idx_type CSR_SMOOTH_COEF  = 3'd4;
   localparam csr_idx_type CSR_DELAY_LEN    = 3'd5;

   // Register values after reset.
   localparam level_type THRESHOLD_RST    = 23'd8388607;
   localparam gain_type  MAKEUP_GAIN_RST  = 25'd262144;
   localparam level_type CEILING_RST      = 23'd8388607;
   localparam coef_type  RELEASE_COEF_RST = 16'd65481;
   localparam coef_type  SMOOTH_COEF_RST  = 16'd65263;
   localparam dlen_type  DELAY_LEN_RST    = 11'd480;

endpackage

// ===== design/sll_serial_mul.sv =====
module sll_serial_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  sll_pkg::mul_cmd_type  cmd,
   input  sll_pkg::mul_word_type mcand,
   input  sll_pkg::mul_word_type mplier,
   output sll_pkg::mul_word_type prod_hi,
   output sll_pkg::mul_word_type prod_lo,
   output logic                  done
);

   sll_pkg::mul_word_type       hi_ff, hi_in;
   sll_pkg::mul_word_type       lo_ff, lo_in;
   sll_pkg::mul_word_type       mcand_ff, mcand_in;
   sll_pkg::mul_cnt_type        cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [sll_pkg::MUL_W:0]     sum;

   // One multiplier bit per cycle, LSB first. The low product bits shift into
   // the top of the multiplier register as its own bits leave at the bottom.
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         hi_in    = '0;
         lo_in    = mplier;
         mcand_in = mcand;
         cnt_in   = cmd.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[sll_pkg::MUL_W:1];
         lo_in  = {sum[0], lo_ff[sll_pkg::MUL_W-1:1]};
         cnt_in = cnt_ff - sll_pkg::mul_cnt_type'(1);
         if (cnt_ff == sll_pkg::mul_cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and product registers.
   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign prod_hi = hi_ff;
   assign prod_lo = lo_ff;
   assign done    = done_ff;

endmodule

// ===== design/stereo_lookahead_limiter.sv =====
// Stereo lookahead peak limiter.
// Requests arrive on the req_ channel, one stereo pair of signed Q1.23 samples
// each, and every request gives one limited pair on the rsp_ channel. The
// csr_ port writes the control registers; it takes a write in any cycle and
// should only be used while no request is in flight.
// Each request passes from acceptance to a result in the output register
// through the two peak stages, the smoothing stage and, when the envelope
// lies above the threshold, the gain division and the makeup product, and
// then the output gain; a peak stage that follows a rise skips its product.
// The work is paced by the serial multiplier of the left lane, which serves
// up to five products and retires one multiplier bit per cycle, and by the
// divider, which produces one quotient bit per cycle. Only one request is
// worked on at a time; req_tready rises together with the load of the result,
// so a new request is taken only once the previous result is in the register.
// After reset the block sweeps its delay memory to zero, one entry per cycle,
// over all MAX_DELAY entries; req_tready stays low during the sweep.
// When the receiver stalls, the result waits in the output register while one
// more request is accepted and computed; that second result then waits until
// the output register is free, and req_tready stays low meanwhile.
module stereo_lookahead_limiter #(
   parameter int MAX_DELAY = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel. tdata: left_sample [23:0], right_sample [47:24].
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2*sll_pkg::SAMPLE_W-1:0] req_tdata,
   // Result channel. tdata: left_out [23:0], right_out [47:24].
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [2*sll_pkg::SAMPLE_W-1:0] rsp_tdata,
   // Control register writes.
   input  logic                           csr_we,
   input  sll_pkg::csr_idx_type           csr_index,
   input  sll_pkg::csr_data_type          csr_wdata
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int PW = AW + 1;
   localparam int PAIR_W = 2 * sll_pkg::SAMPLE_W;
   localparam logic [4:0] DIV_LAST = 5'(sll_pkg::FRAC_BITS - 1);

   typedef enum logic [13:0] {
      ST_CLEAR   = 14'd1 << 0,
      ST_IDLE    = 14'd1 << 1,
      ST_P1_SET  = 14'd1 << 2,
      ST_P1_RUN  = 14'd1 << 3,
      ST_P2_SET  = 14'd1 << 4,
      ST_P2_RUN  = 14'd1 << 5,
      ST_SM_SET  = 14'd1 << 6,
      ST_SM_RUN  = 14'd1 << 7,
      ST_DIV_SET = 14'd1 << 8,
      ST_DIV_RUN = 14'd1 << 9,
      ST_MK_SET  = 14'd1 << 10,
      ST_MK_RUN  = 14'd1 << 11,
      ST_AP_SET  = 14'd1 << 12,
      ST_AP_RUN  = 14'd1 << 13
   } state_type;

   // Magnitude of a sample; the most negative value maps to 2^23 exactly.
   function automatic sll_pkg::mag_type mag_of(input sll_pkg::sample_type x);
      sll_pkg::mag_type u;
      u = sll_pkg::mag_type'(x);
      return x[sll_pkg::SAMPLE_W-1] ? (~u + 1'b1) : u;
   endfunction

   // Clamp a scaled magnitude to the ceiling and restore the sign.
   function automatic sll_pkg::mag_type limit_of(input sll_pkg::scaled_type s,
                                                 input sll_pkg::level_type c,
                                                 input logic neg);
      sll_pkg::mag_type m;
      if (s > sll_pkg::scaled_type'(c)) begin
         m = sll_pkg::mag_type'(c);
      end else begin
         m = sll_pkg::mag_type'(s);
      end
      return neg ? (~m + 1'b1) : m;
   endfunction

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]           ring_ff, ring_in;
   sll_pkg::mag_type        m_ff, m_in;
   sll_pkg::mag_type        p1_ff, p1_in;
   sll_pkg::mag_type        p2_ff, p2_in;
   sll_pkg::mag_type        env_ff, env_in;
   sll_pkg::mag_type        rem_ff, rem_in;
   sll_pkg::quo_type        quo_ff, quo_in;
   logic [4:0]              div_cnt_ff, div_cnt_in;
   sll_pkg::gain_type       total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PAIR_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [PAIR_W-1:0]       rd_data_ff;
   logic [PAIR_W-1:0]       mem_ff [MAX_DELAY];
   logic                    ap_busy_ff, ap_busy_in;

   sll_pkg::level_type      thr_ff, thr_in;
   sll_pkg::gain_type       mkg_ff, mkg_in;
   sll_pkg::level_type      ceil_ff, ceil_in;
   sll_pkg::coef_type       rel_ff, rel_in;
   sll_pkg::coef_type       smc_ff, smc_in;
   sll_pkg::dlen_type       dlen_ff, dlen_in;

   logic                    accept;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [PAIR_W-1:0]       mem_wdata;
   logic [31:0]             dlen_wide;
   logic [PW-1:0]           len_eff;
   logic [PW-1:0]           next_full;
   logic [AW-1:0]           ring_next;
   sll_pkg::mag_type        mag_l_in, mag_r_in;
   sll_pkg::mag_type        mag_dl, mag_dr;
   logic                    env_ge;
   logic [sll_pkg::SAMPLE_W:0] div_trial;
   logic [sll_pkg::SAMPLE_W:0] env_ext;
   sll_pkg::scaled_type     scaled_l, scaled_r;

   sll_pkg::mul_cmd_type    mul0_cmd, mul1_cmd;
   sll_pkg::mul_word_type   mul0_a, mul0_b, mul1_a;
   sll_pkg::mul_word_type   mul0_hi, mul0_lo, mul1_hi, mul1_lo;
   logic                    mul0_done, mul1_done;

   // Left lane does every product; the right lane joins for the output gain.
   sll_serial_mul u_mul_left (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul0_cmd),
      .mcand   (mul0_a),
      .mplier  (mul0_b),
      .prod_hi (mul0_hi),
      .prod_lo (mul0_lo),
      .done    (mul0_done)
   );

   sll_serial_mul u_mul_right (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul1_cmd),
      .mcand   (mul1_a),
      .mplier  (mul0_b),
      .prod_hi (mul1_hi),
      .prod_lo (mul1_lo),
      .done    (mul1_done)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Effective ring length: zero acts as one, anything above the store size
   // acts as the store size.
   always_comb begin
      dlen_wide = 32'(dlen_ff);
      if (dlen_wide == 32'd0) begin
         dlen_wide = 32'd1;
      end else if (dlen_wide > 32'(MAX_DELAY)) begin
         dlen_wide = 32'(MAX_DELAY);
      end
   end

   assign len_eff   = dlen_wide[PW-1:0];
   assign next_full = {1'b0, ring_ff} + {{AW{1'b0}}, 1'b1};
   assign ring_next = (next_full >= len_eff) ? '0 : next_full[AW-1:0];

   // Magnitudes of the incoming pair and of the delayed pair.
   assign mag_l_in = mag_of(sll_pkg::sample_type'(req_tdata[sll_pkg::SAMPLE_W-1:0]));
   assign mag_r_in = mag_of(sll_pkg::sample_type'(req_tdata[PAIR_W-1:sll_pkg::SAMPLE_W]));
   assign mag_dl   = mag_of(sll_pkg::sample_type'(rd_data_ff[sll_pkg::SAMPLE_W-1:0]));
   assign mag_dr   = mag_of(sll_pkg::sample_type'(rd_data_ff[PAIR_W-1:sll_pkg::SAMPLE_W]));

   // Smoothing direction and one restoring division step.
   assign env_ge    = (env_ff >= p2_ff);
   assign env_ext   = {1'b0, env_ff};
   assign div_trial = {rem_ff, 1'b0};

   // Output products shifted down by the gain fraction bits.
   assign scaled_l = {mul0_hi, mul0_lo[sll_pkg::MUL_W-1:sll_pkg::FRAC_BITS]};
   assign scaled_r = {mul1_hi, mul1_lo[sll_pkg::MUL_W-1:sll_pkg::FRAC_BITS]};

   // Delay memory write port: the clearing sweep, then one pair per request.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ring_ff;
      mem_wdata = req_tdata;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (accept) begin
         mem_we = 1'b1;
      end
   end

   // Control registers.
   always_comb begin
      thr_in  = thr_ff;
      mkg_in  = mkg_ff;
      ceil_in = ceil_ff;
      rel_in  = rel_ff;
      smc_in  = smc_ff;
      dlen_in = dlen_ff;
      if (csr_we) begin
         case (csr_index)
            sll_pkg::CSR_THRESHOLD: begin
               thr_in = sll_pkg::level_type'(csr_wdata);
            end
            sll_pkg::CSR_MAKEUP_GAIN: begin
               mkg_in = sll_pkg::gain_type'(csr_wdata);
            end
            sll_pkg::CSR_CEILING: begin
               ceil_in = sll_pkg::level_type'(csr_wdata);
            end
            sll_pkg::CSR_RELEASE_COEF: begin
               rel_in = sll_pkg::coef_type'(csr_wdata);
            end
            sll_pkg::CSR_SMOOTH_COEF: begin
               smc_in = sll_pkg::coef_type'(csr_wdata);
            end
            sll_pkg::CSR_DELAY_LEN: begin
               dlen_in = sll_pkg::dlen_type'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: envelope stages, gain division, makeup and output gain.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      ring_in      = ring_ff;
      m_in         = m_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      env_in       = env_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul0_cmd     = '{start: 1'b0, steps: '0};
      mul1_cmd     = '{start: 1'b0, steps: '0};
      mul0_a       = '0;
      mul0_b       = '0;
      mul1_a       = '0;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(MAX_DELAY - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               m_in     = (mag_l_in > mag_r_in) ? mag_l_in : mag_r_in;
               ring_in  = ring_next;
               state_in = ST_P1_SET;
            end
         end

         // First peak stage: follow a rise at once, otherwise release.
         ST_P1_SET: begin
            if (m_ff > p1_ff) begin
               p1_in    = m_ff;
               state_in = ST_P2_SET;
            end else begin
               mul0_cmd = '{start: 1'b1, steps: sll_pkg::STEPS_COEF};
               mul0_a   = sll_pkg::mul_word_type'(p1_ff - m_ff);
               mul0_b   = sll_pkg::mul_word_type'(rel_ff);
               state_in = ST_P1_RUN;
            end
         end

         ST_P1_RUN: begin
            if (mul0_done) begin
               p1_in    = m_ff + sll_pkg::mag_type'(mul0_hi);
               state_in = ST_P2_SET;
            end
         end

         // Second peak stage, driven by the first.
         ST_P2_SET: begin
            if (p1_ff > p2_ff) begin
               p2_in    = p1_ff;
               state_in = ST_SM_SET;
            end else begin
               mul0_cmd = '{start: 1'b1, steps: sll_pkg::STEPS_COEF};
               mul0_a   = sll_pkg::mul_word_type'(p2_ff - p1_ff);
               mul0_b   = sll_pkg::mul_word_type'(rel_ff);
               state_in = ST_P2_RUN;
            end
         end

         ST_P2_RUN: begin
            if (mul0_done) begin
               p2_in    = p1_ff + sll_pkg::mag_type'(mul0_hi);
               state_in = ST_SM_SET;
            end
         end

         // Smoothing stage; the difference term rounds toward the target.
         ST_SM_SET: begin
            mul0_cmd = '{start: 1'b1, steps: sll_pkg::STEPS_COEF};
            mul0_a   = env_ge ? sll_pkg::mul_word_type'(env_ff - p2_ff)
                              : sll_pkg::mul_word_type'(p2_ff - env_ff);
            mul0_b   = sll_pkg::mul_word_type'(smc_ff);
            state_in = ST_SM_RUN;
         end

         ST_SM_RUN: begin
            if (mul0_done) begin
               env_in   = env_ge ? (p2_ff + sll_pkg::mag_type'(mul0_hi))
                                 : (p2_ff - sll_pkg::mag_type'(mul0_hi));
               state_in = ST_DIV_SET;
            end
         end

         // Above the threshold the gain is threshold / envelope; otherwise
         // unity, so the total gain is the makeup gain itself.
         ST_DIV_SET: begin
            if (env_ff > sll_pkg::mag_type'(thr_ff)) begin
               rem_in     = sll_pkg::mag_type'(thr_ff);
               quo_in     = '0;
               div_cnt_in = '0;
               state_in   = ST_DIV_RUN;
            end else begin
               total_in = mkg_ff;
               state_in = ST_AP_SET;
            end
         end

         // One quotient bit per cycle. The remainder always stays below the
         // envelope, so the upper quotient bits are known to be zero.
         ST_DIV_RUN: begin
            if (div_trial >= env_ext) begin
               rem_in = sll_pkg::mag_type'(div_trial - env_ext);
               quo_in = {quo_ff[sll_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in = sll_pkg::mag_type'(div_trial);
               quo_in = {quo_ff[sll_pkg::FRAC_BITS-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_MK_SET;
            end
         end

         ST_MK_SET: begin
            mul0_cmd = '{start: 1'b1, steps: sll_pkg::STEPS_FRAC};
            mul0_a   = sll_pkg::mul_word_type'(mkg_ff);
            mul0_b   = sll_pkg::mul_word_type'(quo_ff);
            state_in = ST_MK_RUN;
         end

         ST_MK_RUN: begin
            if (mul0_done) begin
               total_in = sll_pkg::gain_type'(mul0_hi);
               state_in = ST_AP_SET;
            end
         end

         // Both channels of the delayed pair are gained side by side.
         ST_AP_SET: begin
            mul0_cmd = '{start: 1'b1, steps: sll_pkg::STEPS_FULL};
            mul1_cmd = '{start: 1'b1, steps: sll_pkg::STEPS_FULL};
            mul0_a   = sll_pkg::mul_word_type'(mag_dl);
            mul1_a   = sll_pkg::mul_word_type'(mag_dr);
            mul0_b   = sll_pkg::mul_word_type'(total_ff);
            state_in = ST_AP_RUN;
         end

         // Hand the result over once the lanes are done and the output
         // register is free.
         ST_AP_RUN: begin
            if (!ap_busy_ff && (!rsp_valid_ff || rsp_tready)) begin
               rsp_data_in  = {limit_of(scaled_r, ceil_ff, rd_data_ff[PAIR_W-1]),
                               limit_of(scaled_l, ceil_ff,
                                        rd_data_ff[sll_pkg::SAMPLE_W-1])};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Tracks whether the output lanes are still running after their start.
   always_comb begin
      ap_busy_in = ap_busy_ff;
      if (state_ff == ST_AP_SET) begin
         ap_busy_in = 1'b1;
      end else if (mul0_done && mul1_done) begin
         ap_busy_in = 1'b0;
      end
   end

   // Control state and envelope state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ring_ff      <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         env_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         ap_busy_ff   <= 1'b0;
         thr_ff       <= sll_pkg::THRESHOLD_RST;
         mkg_ff       <= sll_pkg::MAKEUP_GAIN_RST;
         ceil_ff      <= sll_pkg::CEILING_RST;
         rel_ff       <= sll_pkg::RELEASE_COEF_RST;
         smc_ff       <= sll_pkg::SMOOTH_COEF_RST;
         dlen_ff      <= sll_pkg::DELAY_LEN_RST;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ring_ff      <= ring_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         env_ff       <= env_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ap_busy_ff   <= ap_busy_in;
         thr_ff       <= thr_in;
         mkg_ff       <= mkg_in;
         ceil_ff      <= ceil_in;
         rel_ff       <= rel_in;
         smc_ff       <= smc_in;
         dlen_ff      <= dlen_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Delay memory: one write port, one registered read at the ring position.
   // The delayed pair is read at the advanced ring position after the request's
   // write has landed, so a ring of length one returns the pair just written.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[ring_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/stereo_lookahead_limiter_tb.sv =====
`timescale 1ns / 100ps

module stereo_lookahead_limiter_tb;

   localparam int DELAY_SLOTS   = 1024;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_PAIRS   = 100;
   localparam int unsigned UNITY = 1 << sll_pkg::FRAC_BITS;

   // Bit-exact limiter tracker: mirrors the registers, the envelope and the delay rings,
   // and holds the limited pairs that are still owed by the block.
   class limiter_checker;
      sll_pkg::level_type   thresh;
      sll_pkg::gain_type    makeup;
      sll_pkg::level_type   ceil_level;
      sll_pkg::coef_type    release_k;
      sll_pkg::coef_type    smooth_k;
      sll_pkg::dlen_type    ring_len_reg;
      int unsigned          peak_one;
      int unsigned          peak_two;
      int unsigned          envelope;
      int unsigned          ring_pos;
      sll_pkg::sample_type  left_ring[DELAY_SLOTS];
      sll_pkg::sample_type  right_ring[DELAY_SLOTS];
      sll_pkg::sample_type  owed_left[$];
      sll_pkg::sample_type  owed_right[$];
      int unsigned          fail_count;

      function new();
         thresh       = sll_pkg::THRESHOLD_RST;
         makeup       = sll_pkg::MAKEUP_GAIN_RST;
         ceil_level   = sll_pkg::CEILING_RST;
         release_k    = sll_pkg::RELEASE_COEF_RST;
         smooth_k     = sll_pkg::SMOOTH_COEF_RST;
         ring_len_reg = sll_pkg::DELAY_LEN_RST;
         peak_one     = 0;
         peak_two     = 0;
         envelope     = 0;
         ring_pos     = 0;
         fail_count   = 0;
         foreach (left_ring[i]) begin
            left_ring[i]  = '0;
            right_ring[i] = '0;
         end
      endfunction

      // Bits above a register's width are dropped; unmapped indexes do nothing.
      function void write_reg(sll_pkg::csr_idx_type idx, sll_pkg::csr_data_type value);
         case (idx)
            sll_pkg::CSR_THRESHOLD:    thresh       = value[sll_pkg::LEVEL_W-1:0];
            sll_pkg::CSR_MAKEUP_GAIN:  makeup       = value[sll_pkg::GAIN_W-1:0];
            sll_pkg::CSR_CEILING:      ceil_level   = value[sll_pkg::LEVEL_W-1:0];
            sll_pkg::CSR_RELEASE_COEF: release_k    = value[sll_pkg::COEF_W-1:0];
            sll_pkg::CSR_SMOOTH_COEF:  smooth_k     = value[sll_pkg::COEF_W-1:0];
            sll_pkg::CSR_DELAY_LEN:    ring_len_reg = value[sll_pkg::DLEN_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned magnitude(sll_pkg::sample_type x);
         int wide_x;
         wide_x = int'(x);
         return (wide_x < 0) ? unsigned'(-wide_x) : unsigned'(wide_x);
      endfunction

      // Peak hold with exponential release toward the new level.
      function int unsigned hold_peak(int unsigned level, int unsigned prev,
                                      sll_pkg::coef_type k);
         longint unsigned part;
         if (level > prev) begin
            return level;
         end
         part = 64'(prev - level);
         part = (part * k) >> 16;
         return level + part[31:0];
      endfunction

      // One-pole smoothing; the truncated difference term rounds toward the aim.
      function int unsigned smooth_toward(int unsigned aim, int unsigned prev,
                                          sll_pkg::coef_type k);
         longint unsigned part;
         if (prev >= aim) begin
            part = 64'(prev - aim);
            part = (part * k) >> 16;
            return aim + part[31:0];
         end
         part = 64'(aim - prev);
         part = (part * k) >> 16;
         return aim - part[31:0];
      endfunction

      function sll_pkg::sample_type gain_sample(sll_pkg::sample_type x, int unsigned total);
         longint unsigned     scaled;
         sll_pkg::sample_type lim;
         scaled = 64'(magnitude(x));
         scaled = (scaled * total) >> sll_pkg::FRAC_BITS;
         if (scaled > 64'(ceil_level)) begin
            scaled = 64'(ceil_level);
         end
         lim = scaled[sll_pkg::SAMPLE_W-1:0];
         return (x < 0) ? -lim : lim;
      endfunction

      // Advances the limiter by one accepted request and queues the pair it owes.
      function void note_pair_in(sll_pkg::sample_type left, sll_pkg::sample_type right);
         int unsigned     level;
         int unsigned     len;
         int unsigned     pos;
         int unsigned     nxt;
         int unsigned     gain;
         int unsigned     total;
         longint unsigned wide;
         level = magnitude(left);
         if (magnitude(right) > level) begin
            level = magnitude(right);
         end
         len = 32'(ring_len_reg);
         if (len < 1) begin
            len = 1;
         end
         if (len > DELAY_SLOTS) begin
            len = DELAY_SLOTS;
         end
         pos = ring_pos % DELAY_SLOTS;

         peak_one = hold_peak(level, peak_one, release_k);
         peak_two = hold_peak(peak_one, peak_two, release_k);
         envelope = smooth_toward(peak_two, envelope, smooth_k);

         // Write at the current slot, read back at the next one.
         left_ring[pos]  = left;
         right_ring[pos] = right;
         nxt = pos + 1;
         if (nxt >= len) begin
            nxt = 0;
         end
         ring_pos = nxt;

         if (envelope > thresh) begin
            wide = 64'(thresh);
            wide = (wide << sll_pkg::FRAC_BITS) / envelope;
            gain = wide[31:0];
         end else begin
            gain = UNITY;
         end
         wide = 64'(gain);
         wide = (wide * makeup) >> sll_pkg::FRAC_BITS;
         total = wide[31:0];

         owed_left.push_back(gain_sample(left_ring[nxt], total));
         owed_right.push_back(gain_sample(right_ring[nxt], total));
      endfunction

      function void check_pair_out(sll_pkg::sample_type left, sll_pkg::sample_type right);
         sll_pkg::sample_type exp_left;
         sll_pkg::sample_type exp_right;
         if (owed_left.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected result: left %0d right %0d", left, right);
            end
            fail_count++;
            return;
         end
         exp_left  = owed_left.pop_front();
         exp_right = owed_right.pop_front();
         if (left !== exp_left || right !== exp_right) begin
            if (fail_count < 10) begin
               $display("mismatch: expected left %0d right %0d, got left %0d right %0d",
                        exp_left, exp_right, left, right);
            end
            fail_count++;
         end
      endfunction

      function int pending();
         return owed_left.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [2*sll_pkg::SAMPLE_W-1:0] req_tdata;   // left_sample [23:0], right_sample [47:24]
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [2*sll_pkg::SAMPLE_W-1:0] rsp_tdata;   // left_out [23:0], right_out [47:24]
   logic                           csr_we;
   sll_pkg::csr_idx_type           csr_index;
   sll_pkg::csr_data_type          csr_wdata;

   bit                             steady_flow = 1'b0;
   int unsigned                    cycle_count = 0;
   limiter_checker                 tracker;

   stereo_lookahead_limiter #(
      .MAX_DELAY (DELAY_SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Observe register writes, accepted requests and accepted results at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            tracker.write_reg(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            tracker.note_pair_in(req_tdata[sll_pkg::SAMPLE_W-1:0],
                                 req_tdata[2*sll_pkg::SAMPLE_W-1:sll_pkg::SAMPLE_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_pair_out(rsp_tdata[sll_pkg::SAMPLE_W-1:0],
                                   rsp_tdata[2*sll_pkg::SAMPLE_W-1:sll_pkg::SAMPLE_W]);
         end
      end
   end

   // Result receiver with a random stall before each result, none in steady-flow phases.
   initial begin : result_sink
      int unsigned stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Sends one stereo request after a random gap (none in steady-flow phases); returns at the accepting edge.
   task automatic send_pair(input sll_pkg::sample_type left,
                            input sll_pkg::sample_type right);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds off new requests until every owed result has been taken.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic put_reg(input sll_pkg::csr_idx_type idx, input sll_pkg::csr_data_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes every register, then one unmapped index that must change nothing.
   task automatic load_regs(input sll_pkg::csr_data_type thr,
                            input sll_pkg::csr_data_type gain,
                            input sll_pkg::csr_data_type ceil_v,
                            input sll_pkg::csr_data_type rel,
                            input sll_pkg::csr_data_type smo,
                            input sll_pkg::csr_data_type len);
      put_reg(sll_pkg::CSR_THRESHOLD, thr);
      put_reg(sll_pkg::CSR_MAKEUP_GAIN, gain);
      put_reg(sll_pkg::CSR_CEILING, ceil_v);
      put_reg(sll_pkg::CSR_RELEASE_COEF, rel);
      put_reg(sll_pkg::CSR_SMOOTH_COEF, smo);
      put_reg(sll_pkg::CSR_DELAY_LEN, len);
      put_reg(sll_pkg::csr_idx_type'(sll_pkg::CSR_DELAY_LEN + 1 + $urandom_range(0, 1)),
              sll_pkg::csr_data_type'($urandom));
      csr_we <= 1'b0;
   endtask

   // Mode 1 forces the low end, mode 2 all ones, mode 0 mixes extremes, raw words
   // with bits above the width, and a typical range.
   function automatic sll_pkg::csr_data_type draw_reg(input int width, input int mode,
                                                      input int unsigned lo,
                                                      input int unsigned hi);
      sll_pkg::csr_data_type top;
      top = sll_pkg::csr_data_type'((1 << width) - 1);
      if (mode == 1) begin
         return '0;
      end
      if (mode == 2) begin
         return top;
      end
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return top;
         2:       return sll_pkg::csr_data_type'($urandom);
         default: return sll_pkg::csr_data_type'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic sll_pkg::sample_type draw_sample();
      case ($urandom_range(0, 7))
         0:       return {1'b1, {(sll_pkg::SAMPLE_W-1){1'b0}}};
         1:       return {1'b0, {(sll_pkg::SAMPLE_W-1){1'b1}}};
         2:       return sll_pkg::sample_type'($urandom_range(0, 2000))
                         - sll_pkg::sample_type'(1000);
         default: return sll_pkg::sample_type'($urandom);
      endcase
   endfunction

   // Directed checks of corner values and of the delay length handling.
   task automatic run_directed();
      sll_pkg::sample_type edge_left[9];
      sll_pkg::sample_type edge_right[9];
      edge_left  = '{24'sd0, 24'sh7FFFFF, 24'sh800000, -24'sd1, 24'sd1,
                     24'sh7FFFFF, 24'sh800000, 24'sh555555, 24'shAAAAAA};
      edge_right = '{24'sd0, 24'sh800000, 24'sh7FFFFF, 24'sd1, -24'sd1,
                     24'sh7FFFFF, 24'sh800000, 24'shAAAAAA, 24'sh555555};

      // Length of one gives no delay; the threshold word carries bits above its width.
      load_regs({2'b11, 23'd4194304}, sll_pkg::csr_data_type'(UNITY),
                sll_pkg::csr_data_type'(sll_pkg::CEILING_RST),
                sll_pkg::csr_data_type'(sll_pkg::RELEASE_COEF_RST), '0,
                sll_pkg::csr_data_type'(1));
      foreach (edge_left[i]) begin
         send_pair(edge_left[i], edge_right[i]);
      end
      drain_results();

      // A zero length acts as one; zero threshold and zero ceiling silence the output.
      load_regs('0, 25'h1FFFFFF, '0, '0, 25'h000FFFF, '0);
      send_pair(24'sh7FFFFF, 24'sh800000);
      send_pair(24'sd100, -24'sd100);
      send_pair(24'sd0, 24'sd0);
      drain_results();

      // A length above the store size acts as the full store.
      load_regs(sll_pkg::csr_data_type'(sll_pkg::THRESHOLD_RST), 25'h1FFFFFF,
                25'd4194304, 25'h000FFFF, 25'h000FFFF, 25'h1FFFFFF);
      repeat (6) send_pair(draw_sample(), draw_sample());
      drain_results();

      // Shrinking the ring below the write position wraps it on the next advance.
      load_regs(25'd1000, sll_pkg::csr_data_type'(UNITY),
                sll_pkg::csr_data_type'(sll_pkg::CEILING_RST),
                sll_pkg::csr_data_type'(sll_pkg::RELEASE_COEF_RST),
                sll_pkg::csr_data_type'(sll_pkg::SMOOTH_COEF_RST), 25'h1FFF804);
      repeat (6) send_pair(draw_sample(), draw_sample());
      drain_results();
   endtask

   initial begin : stimulus
      int mode;
      tracker = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random phases: the first two pin every register to its ends.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady_flow = (p % 4 == 3);
         mode = (p < 2) ? p + 1 : 0;
         load_regs(draw_reg(sll_pkg::LEVEL_W, mode, 0, (1 << sll_pkg::LEVEL_W) - 1),
                   draw_reg(sll_pkg::GAIN_W, mode, UNITY / 2, 4 * UNITY),
                   draw_reg(sll_pkg::LEVEL_W, mode, 1 << (sll_pkg::LEVEL_W - 1),
                            (1 << sll_pkg::LEVEL_W) - 1),
                   draw_reg(sll_pkg::COEF_W, mode, 32768, (1 << sll_pkg::COEF_W) - 1),
                   draw_reg(sll_pkg::COEF_W, mode, 32768, (1 << sll_pkg::COEF_W) - 1),
                   draw_reg(sll_pkg::DLEN_W, mode, 1, 40));
         repeat (PHASE_PAIRS) send_pair(draw_sample(), draw_sample());
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.fail_count == 0 && tracker.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
